[rtl/core/subfm_pkg.sv]
// Package for the substring first-match unit: field widths, defaults,
// command codes and the control bundle shared by the matcher cells.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package subfm_pkg;

    localparam int MAX_NEEDLE_DEF     = 64;
    localparam int POSITION_WIDTH_DEF = 32;

    localparam int CFG_W   = 7;
    localparam int SLOT_W  = 6;
    localparam int BYTE_W  = 8;
    localparam int START_W = 32;

    localparam logic [CFG_W-1:0] PATTERN_LENGTH_RST = CFG_W'(1);

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_FEED = 1'b1
    } t_cmd;

    // broadcast to every cell for one accepted request
    typedef struct packed {
        logic              feed;
        logic              clear;
        logic [BYTE_W-1:0] data;
    } t_cell_ctrl;

endpackage

`default_nettype wire

[rtl/core/subfm_if.sv]
// Request and result channel interfaces of the substring first-match unit.
// Depends on subfm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface subfm_in_if;
    import subfm_pkg::*;

    logic              valid;
    logic              ready;
    logic              command;
    logic [SLOT_W-1:0] slot_index;
    logic [BYTE_W-1:0] data_byte;
    logic              is_last;

    modport source (output valid, command, slot_index, data_byte, is_last, input ready);
    modport sink   (input valid, command, slot_index, data_byte, is_last, output ready);
endinterface

interface subfm_out_if;
    import subfm_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic [START_W-1:0] match_start;
    logic               search_done;

    modport source (output valid, found, match_start, search_done, input ready);
    modport sink   (input valid, found, match_start, search_done, output ready);
endinterface

`default_nettype wire

[rtl/core/subfm_cell.sv]
// One alignment cell: holds a pattern byte and its partial-match flag,
// and passes the flag to the next cell. Depends on subfm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module subfm_cell #(
    parameter int INDEX = 0,
    parameter int LEN_W = 7
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire subfm_pkg::t_cell_ctrl i_ctrl,
    input  wire logic                  i_load_en,
    input  wire logic                  i_prev_flag,
    input  wire logic [LEN_W-1:0]      i_len,
    output logic                       o_flag,
    output logic                       o_hit
);
    import subfm_pkg::*;

    logic [BYTE_W-1:0] r_pat;
    logic              r_flag;
    logic              n_flag;
    logic              w_active;
    logic              w_tail;
    logic              w_match;

    assign w_active = 32'(i_len) > 32'(INDEX);
    assign w_tail   = 32'(i_len) == 32'(INDEX + 1);
    assign w_match  = i_prev_flag && (r_pat == i_ctrl.data);

    always_comb begin
        n_flag = r_flag;
        if (i_ctrl.clear) begin
            n_flag = 1'b0;
        end else if (i_ctrl.feed && w_active) begin
            n_flag = w_match;
        end
    end

    // hit uses the freshly updated flag, before any end-of-search clear
    assign o_hit  = i_ctrl.feed && w_active && w_tail && w_match;
    assign o_flag = r_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
        end else begin
            r_flag <= n_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_en) begin
            r_pat <= i_ctrl.data;
        end
    end

endmodule

`default_nettype wire

[rtl/core/substring_first_match_unit.sv]
// Top level of the substring first-match unit: row of alignment cells,
// position tracking and the result register. Depends on subfm_pkg,
// subfm_if and subfm_cell.
//
// Usage: i_in carries requests. A load request (command 0) writes data_byte
// into pattern slot slot_index; a feed request (command 1) shifts one
// haystack byte through all alignments at once. i_cfg_we/i_cfg_wdata set the
// pattern length (reset value 1); write it only while no request is in
// flight. Every request gives exactly one result on o_out: found,
// match_start of the first full match, and search_done on the result of a
// feed with is_last set, after which the search state clears.
// The result is registered and presented in the cycle after the request is taken.
// Throughput: one request per cycle, set by the single result register;
// all pattern alignments update in parallel in the cell row.
// A stalled o_out holds its result and i_in.ready drops until it is taken.
// Reset (synchronous, active low) clears the search state and the result
// valid, and sets the pattern length to one; pattern bytes hold no value
// until loaded.
`timescale 1ns / 1ps
`default_nettype none

module substring_first_match_unit #(
    parameter int MAX_NEEDLE     = subfm_pkg::MAX_NEEDLE_DEF,
    parameter int POSITION_WIDTH = subfm_pkg::POSITION_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    subfm_in_if.sink                          i_in,
    subfm_out_if.source                       o_out,
    input  wire logic                         i_cfg_we,
    input  wire logic [subfm_pkg::CFG_W-1:0]  i_cfg_wdata
);
    import subfm_pkg::*;

    localparam int LEN_W = $clog2(MAX_NEEDLE + 1);
    localparam int PW    = POSITION_WIDTH;
    localparam int SW    = PW + LEN_W;

    logic [CFG_W-1:0]   r_pattern_length;
    logic [PW-1:0]      r_pos;
    logic               r_seen;
    logic [PW-1:0]      r_start;
    logic               r_out_valid;
    logic               r_found;
    logic [START_W-1:0] r_match_start;
    logic               r_done;

    logic [PW-1:0]      n_pos;
    logic               n_seen;
    logic [PW-1:0]      n_start;
    logic               n_found_out;
    logic [PW-1:0]      n_start_out;

    logic               w_accept;
    logic               w_feed;
    logic               w_done;
    logic [LEN_W-1:0]   w_len;
    logic [31:0]        w_len_raw;
    t_cell_ctrl         w_ctrl;
    logic [MAX_NEEDLE-1:0] w_flag;
    logic [MAX_NEEDLE-1:0] w_hit;
    logic               w_hit_any;
    logic [SW-1:0]      w_pos_ext;
    logic [SW-1:0]      w_off;
    logic [SW-1:0]      w_diff;
    logic [PW-1:0]      w_hit_start;
    logic [PW+START_W-1:0] w_start_ext;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_feed     = w_accept && (i_in.command == CMD_FEED);
    assign w_done     = w_feed && i_in.is_last;

    assign w_len_raw = (32'(r_pattern_length) > 32'(MAX_NEEDLE)) ?
                       32'(MAX_NEEDLE) : 32'(r_pattern_length);
    assign w_len     = LEN_W'(w_len_raw);

    assign w_ctrl.feed  = w_feed;
    assign w_ctrl.clear = w_done;
    assign w_ctrl.data  = i_in.data_byte;

    for (genvar gi = 0; gi < MAX_NEEDLE; gi++) begin : g_cell
        logic w_load_en;
        logic w_prev;

        assign w_load_en = w_accept && (i_in.command == CMD_LOAD) &&
                           (32'(i_in.slot_index) == 32'(gi));
        if (gi == 0) begin : g_head
            assign w_prev = 1'b1;
        end else begin : g_link
            assign w_prev = w_flag[gi-1];
        end

        subfm_cell #(
            .INDEX (gi),
            .LEN_W (LEN_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_load_en   (w_load_en),
            .i_prev_flag (w_prev),
            .i_len       (w_len),
            .o_flag      (w_flag[gi]),
            .o_hit       (w_hit[gi])
        );
    end

    assign w_hit_any = |w_hit;

    // start = pos - (len - 1), floored at zero
    assign w_pos_ext   = SW'(r_pos);
    assign w_off       = SW'(w_len) - SW'(1);
    assign w_diff      = w_pos_ext - w_off;
    assign w_hit_start = (w_pos_ext >= w_off) ? PW'(w_diff) : '0;

    always_comb begin
        n_pos       = r_pos;
        n_seen      = r_seen;
        n_start     = r_start;
        n_found_out = r_seen;
        n_start_out = r_start;
        if (w_feed) begin
            if (r_pos != '1) begin
                n_pos = r_pos + PW'(1);
            end
            if (!r_seen) begin
                if (w_len == '0) begin
                    n_seen  = 1'b1;
                    n_start = '0;
                end else if (w_hit_any) begin
                    n_seen  = 1'b1;
                    n_start = w_hit_start;
                end
            end
            n_found_out = n_seen;
            n_start_out = n_seen ? n_start : '0;
            if (w_done) begin
                n_pos   = '0;
                n_seen  = 1'b0;
                n_start = '0;
            end
        end
    end

    assign w_start_ext = {{START_W{1'b0}}, n_start_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= PATTERN_LENGTH_RST;
            r_pos            <= '0;
            r_seen           <= 1'b0;
            r_start          <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pattern_length <= i_cfg_wdata;
            end
            r_pos   <= n_pos;
            r_seen  <= n_seen;
            r_start <= n_start;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_found       <= n_found_out;
            r_match_start <= w_start_ext[START_W-1:0];
            r_done        <= w_done;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.found       = r_found;
    assign o_out.match_start = r_match_start;
    assign o_out.search_done = r_done;

`ifndef SYNTHESIS
    a_clear_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> !r_seen && (r_pos == '0))
        else $error("search state not cleared after last byte");

    a_seen_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen && !w_done |=> r_seen)
        else $error("match flag dropped mid-search");

    // only a search with no earlier match reports the empty pattern at zero
    a_empty_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_feed && (w_len == '0) && !r_seen |=> o_out.valid && o_out.found
            && (o_out.match_start == '0))
        else $error("empty pattern did not match at start");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |-> !w_accept)
        else $error("request taken while result stalled");
`endif

endmodule

`default_nettype wire
